[src/infix_to_postfix_converter_assert.svh]
// ============================================================================
// Assertion macros for the infix to postfix converter
// Shared macros that write labeled concurrent assertions on the block clock.
// ============================================================================
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Property checked at every rising edge of clk, quiet while rst is high.
`define ITP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, reset cycles included.
`define ITP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/itp_pkg.sv]
// ============================================================================
// Infix to postfix converter package
// Character codes, stack codes, status codes and the control structs.
// ============================================================================
package itp_pkg;

  // ASCII characters the converter reacts to.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Codes held on the operator stack.
  localparam logic [2:0] CODE_OPEN  = 3'd0;
  localparam logic [2:0] CODE_PLUS  = 3'd1;
  localparam logic [2:0] CODE_MINUS = 3'd2;
  localparam logic [2:0] CODE_STAR  = 3'd3;
  localparam logic [2:0] CODE_SLASH = 3'd4;
  localparam logic [2:0] CODE_CARET = 3'd5;

  // Precedence levels.
  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK              = 2'd0;
  localparam logic [1:0] ST_OVERFLOW        = 2'd1;
  localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd2;
  localparam logic [1:0] ST_UNMATCHED_OPEN  = 2'd3;

  // Character classes.
  localparam logic [2:0] CLS_ALNUM = 3'd0;
  localparam logic [2:0] CLS_OPEN  = 3'd1;
  localparam logic [2:0] CLS_CLOSE = 3'd2;
  localparam logic [2:0] CLS_OPER  = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  // Sources of the result character.
  localparam logic [1:0] ESEL_SYMBOL = 2'd0;
  localparam logic [1:0] ESEL_TOS    = 2'd1;
  localparam logic [1:0] ESEL_ZERO   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       push;
    logic       pop;
    logic       emit;
    logic [1:0] esel;
    logic [1:0] estatus;
    logic       edone;
    logic       elast;
    logic       mark_open;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cls;
    logic       eoe;
    logic       empty;
    logic       one;
    logic       full;
    logic       tos_open;
    logic       tos_ge;
    logic       nxt_open;
    logic       nxt_lt;
    logic       slot_free;
    logic       open_seen;
  } dp_stat_t;

  // Stack code to its ASCII character.
  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] ch;
    unique case (code)
      CODE_OPEN:  ch = CH_OPEN;
      CODE_PLUS:  ch = CH_PLUS;
      CODE_MINUS: ch = CH_MINUS;
      CODE_STAR:  ch = CH_STAR;
      CODE_SLASH: ch = CH_SLASH;
      CODE_CARET: ch = CH_CARET;
      default:    ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Stack code to its precedence.
  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      CODE_PLUS, CODE_MINUS: p = PREC_ADD;
      CODE_STAR, CODE_SLASH: p = PREC_MUL;
      CODE_CARET:            p = PREC_POW;
      default:               p = PREC_NONE;
    endcase
    return p;
  endfunction

  // Operator character to its stack code; anything else maps to the open code.
  function automatic logic [2:0] op_code(input logic [7:0] ch);
    logic [2:0] c;
    unique case (ch)
      CH_PLUS:  c = CODE_PLUS;
      CH_MINUS: c = CODE_MINUS;
      CH_STAR:  c = CODE_STAR;
      CH_SLASH: c = CODE_SLASH;
      CH_CARET: c = CODE_CARET;
      default:  c = CODE_OPEN;
    endcase
    return c;
  endfunction

  // Sorts a character into the class that decides its handling.
  function automatic logic [2:0] classify(input logic [7:0] ch);
    logic [2:0] cls;
    if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
        (ch >= 8'h30 && ch <= 8'h39)) begin
      cls = CLS_ALNUM;
    end else if (ch == CH_OPEN) begin
      cls = CLS_OPEN;
    end else if (ch == CH_CLOSE) begin
      cls = CLS_CLOSE;
    end else if (op_code(ch) != CODE_OPEN) begin
      cls = CLS_OPER;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

[src/itp_in_if.sv]
// ============================================================================
// Input channel of the infix to postfix converter
// Valid/ready channel that carries one infix character per transfer.
// ============================================================================
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, symbol, end_of_expression, input ready);
  modport sink (input valid, symbol, end_of_expression, output ready);
endinterface

[src/itp_out_if.sv]
// ============================================================================
// Output channel of the infix to postfix converter
// Valid/ready channel that carries one postfix result per transfer.
// ============================================================================
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       run_last;
  logic       expression_done;
  logic [1:0] status;

  modport source (output valid, out_symbol, run_last, expression_done, status,
                  input ready);
  modport sink (input valid, out_symbol, run_last, expression_done, status,
                output ready);
endinterface

[src/infix_to_postfix_converter.sv]
// ============================================================================
// Infix to postfix converter
// Shunting-yard conversion of an ASCII character stream with an operator stack.
// ============================================================================
//   Channel  Direction  Carries
//   din      sink       symbol, end_of_expression
//   dout     source     out_symbol, run_last, expression_done, status
//
// Operands, '(' and ignored characters are accepted, then dispatched; ')' and
// operators pop operators, then pop the '(', push or give a status; the end mark
// pops each entry and emits the terminator. Pops go one a cycle when dout is free.
// rst is synchronous and empties the stack and the result register.
// A result waits in the output register while dout is stalled, and the next
// processing step waits with it; din is ready only between items.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  itp_in_if.sink     din,
  itp_out_if.source  dout
);

  itp_pkg::dp_cmd_t  cmd;
  itp_pkg::dp_stat_t stat;

  // Sequencing of each character.
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stack and result storage.
  itp_dp #(
    .DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .symbol            (din.symbol),
    .end_of_expression (din.end_of_expression),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (dout.valid),
    .out_ready         (dout.ready),
    .out_symbol        (dout.out_symbol),
    .run_last          (dout.run_last),
    .expression_done   (dout.expression_done),
    .status            (dout.status)
  );

endmodule

[src/itp_dp.sv]
// ============================================================================
// Infix to postfix converter datapath
// Operator stack with a top register, held character and the result register.
// ============================================================================
module itp_dp #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        symbol,
  input  logic              end_of_expression,
  input  itp_pkg::dp_cmd_t  cmd,
  output itp_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_symbol,
  output logic              run_last,
  output logic              expression_done,
  output logic [1:0]        status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] rd_full;
  logic [CW-1:0] wr_full;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [2:0]    mem [DEPTH];
  logic [2:0]    tos;
  logic [2:0]    rd;
  logic [7:0]    sym;
  logic          eoe;
  logic          open_flag;
  logic [2:0]    sym_code;
  logic [1:0]    sym_prec;

  assign sym_code = itp_pkg::op_code(sym);
  assign sym_prec = itp_pkg::code_prec(sym_code);

  // Stack depth bookkeeping; push and pop never come together.
  always_comb begin
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  // The top entry sits in tos; the memory holds the entries below it, and rd
  // is kept loaded with the entry just under the top.
  assign rd_full = count_next - CW'(2);
  assign wr_full = count - CW'(1);
  assign rd_addr = rd_full[AW-1:0];
  assign wr_addr = wr_full[AW-1:0];
  assign wr_en   = cmd.push && (count != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= tos;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd <= tos;
    end else begin
      rd <= mem[rd_addr];
    end
  end

  // Top of stack and depth count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tos <= sym_code;
    end else if (cmd.pop) begin
      tos <= rd;
    end
  end

  // Held input character and the open-paren flag of the end flush.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym <= symbol;
      eoe <= end_of_expression;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag <= 1'b0;
    end else if (cmd.latch) begin
      open_flag <= 1'b0;
    end else if (cmd.mark_open) begin
      open_flag <= 1'b1;
    end
  end

  // Result register: loaded on emit, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.esel)
        itp_pkg::ESEL_SYMBOL: out_symbol <= sym;
        itp_pkg::ESEL_TOS:    out_symbol <= itp_pkg::code_char(tos);
        default:              out_symbol <= itp_pkg::CH_NUL;
      endcase
      run_last        <= cmd.elast;
      expression_done <= cmd.edone;
      status          <= cmd.estatus;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.cls       = itp_pkg::classify(sym);
    stat.eoe       = eoe;
    stat.empty     = (count == '0);
    stat.one       = (count == CW'(1));
    stat.full      = (count == CW'(DEPTH));
    stat.tos_open  = (tos == itp_pkg::CODE_OPEN);
    stat.tos_ge    = (itp_pkg::code_prec(tos) >= sym_prec);
    stat.nxt_open  = (rd == itp_pkg::CODE_OPEN);
    stat.nxt_lt    = (itp_pkg::code_prec(rd) < sym_prec);
    stat.slot_free = !out_valid || out_ready;
    stat.open_seen = open_flag;
  end

endmodule

[src/itp_ctrl.sv]
// ============================================================================
// Infix to postfix converter controller
// State machine that sequences dispatch, pops, pushes and the end flush.
// ============================================================================
module itp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itp_pkg::dp_stat_t stat,
  output itp_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_CLOSE    = 3'd2;
  localparam logic [2:0] S_OPPOP    = 3'd3;
  localparam logic [2:0] S_FLUSH    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after_item;

  assign in_ready   = (state == S_IDLE);
  assign after_item = stat.eoe ? S_FLUSH : S_IDLE;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands; dispatch and every step after it wait for a free slot.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.slot_free) begin
          unique case (stat.cls)
            itp_pkg::CLS_ALNUM: begin
              cmd.emit   = 1'b1;
              cmd.esel   = itp_pkg::ESEL_SYMBOL;
              cmd.elast  = !stat.eoe;
              state_next = after_item;
            end
            itp_pkg::CLS_OPEN: begin
              if (stat.full) begin
                cmd.emit    = 1'b1;
                cmd.esel    = itp_pkg::ESEL_ZERO;
                cmd.estatus = itp_pkg::ST_OVERFLOW;
                cmd.elast   = !stat.eoe;
              end else begin
                cmd.push = 1'b1;
              end
              state_next = after_item;
            end
            itp_pkg::CLS_CLOSE: state_next = S_CLOSE;
            itp_pkg::CLS_OPER:  state_next = S_OPPOP;
            default:            state_next = after_item;
          endcase
        end
      end
      S_CLOSE: begin
        if (stat.slot_free) begin
          if (stat.empty) begin
            cmd.emit    = 1'b1;
            cmd.esel    = itp_pkg::ESEL_ZERO;
            cmd.estatus = itp_pkg::ST_UNMATCHED_CLOSE;
            cmd.elast   = !stat.eoe;
            state_next  = after_item;
          end else if (stat.tos_open) begin
            cmd.pop    = 1'b1;
            state_next = after_item;
          end else begin
            // Last result when the entry below is the matching paren.
            cmd.emit  = 1'b1;
            cmd.esel  = itp_pkg::ESEL_TOS;
            cmd.elast = !stat.eoe && !stat.one && stat.nxt_open;
            cmd.pop   = 1'b1;
          end
        end
      end
      S_OPPOP: begin
        if (stat.slot_free) begin
          if (!stat.empty && !stat.tos_open && stat.tos_ge) begin
            // Last result when the entry below stops the popping.
            cmd.emit  = 1'b1;
            cmd.esel  = itp_pkg::ESEL_TOS;
            cmd.elast = !stat.eoe && (stat.one || stat.nxt_open || stat.nxt_lt);
            cmd.pop   = 1'b1;
          end else begin
            if (stat.full) begin
              cmd.emit    = 1'b1;
              cmd.esel    = itp_pkg::ESEL_ZERO;
              cmd.estatus = itp_pkg::ST_OVERFLOW;
              cmd.elast   = !stat.eoe;
            end else begin
              cmd.push = 1'b1;
            end
            state_next = after_item;
          end
        end
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          if (stat.empty) begin
            cmd.emit    = 1'b1;
            cmd.esel    = itp_pkg::ESEL_ZERO;
            cmd.edone   = 1'b1;
            cmd.elast   = 1'b1;
            cmd.estatus = stat.open_seen ? itp_pkg::ST_UNMATCHED_OPEN : itp_pkg::ST_OK;
            state_next  = S_IDLE;
          end else begin
            cmd.pop = 1'b1;
            if (stat.tos_open) begin
              cmd.mark_open = 1'b1;
            end else begin
              cmd.emit = 1'b1;
              cmd.esel = itp_pkg::ESEL_TOS;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/itp_checker.sv]
// ============================================================================
// Infix to postfix converter port checker
// Concurrent checks on the channel ports, attached to the top level by bind.
// ============================================================================
`include "infix_to_postfix_converter_assert.svh"

module itp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic       run_last,
  input logic       expression_done,
  input logic [1:0] status
);

  // A stalled result keeps its character.
  `ITP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_symbol), "result changed while stalled")

  // The terminator is a zero character and ends its item's run.
  `ITP_ASSERT(a_done_last, out_valid && expression_done |-> run_last && out_symbol == itp_pkg::CH_NUL, "terminator malformed")

  // Error results carry no character.
  `ITP_ASSERT(a_status_zero, out_valid && status != itp_pkg::ST_OK |-> out_symbol == itp_pkg::CH_NUL, "status result carries a character")

  // An unmatched open paren is only reported on the terminator.
  `ITP_ASSERT(a_open_on_done, out_valid && status == itp_pkg::ST_UNMATCHED_OPEN |-> expression_done, "open paren status off terminator")

  // Items are taken one at a time: no transfer in the cycle after one.
  `ITP_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while an item is in work")

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (din.valid),
  .in_ready        (din.ready),
  .out_valid       (dout.valid),
  .out_ready       (dout.ready),
  .out_symbol      (dout.out_symbol),
  .run_last        (dout.run_last),
  .expression_done (dout.expression_done),
  .status          (dout.status)
);

[tb/infix_to_postfix_converter_tb.sv]
// ============================================================================
// Infix to postfix converter testbench
// Feeds infix character streams over the input channel and checks every
// postfix transfer against a shunting-yard predictor kept in the bench.
// Directed expressions cover operators, parentheses and unmatched parens;
// random expressions, noise, broken and deeply nested streams follow.
// ============================================================================
module infix_to_postfix_converter_tb;

  localparam int STACK_DEPTH = 32;
  localparam int CHAR_TARGET = 310;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] symbol;
    logic       eoe;
  } infix_char_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       run_last;
    logic       expression_done;
    logic [1:0] status;
  } postfix_t;

  logic clk = 1'b0;
  logic rst;

  itp_in_if  in_ch ();
  itp_out_if out_ch ();

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .din (in_ch),
    .dout(out_ch)
  );

  // Clock with a 20 unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Characters waiting to be sent and postfix results still owed.
  infix_char_t feed[$];
  postfix_t    postfix_expect[$];
  postfix_t    item_run[$];

  // Predictor state: the operator stack as the block should hold it.
  logic [2:0] op_stack[STACK_DEPTH];
  int         op_depth = 0;

  int  planned_chars = 0;
  bit  noisy = 1'b0;
  int  chars_in = 0;
  int  results_seen = 0;
  int  exprs_closed = 0;
  int  status_seen[4] = '{0, 0, 0, 0};
  int  error_count = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  int  gap_left = 0;
  int  burst_left = 1;
  int  sink_tick = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // Character classes as the converter sees them.
  function automatic bit is_operand(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
           (ch >= "0" && ch <= "9");
  endfunction

  function automatic logic [2:0] operator_code(input logic [7:0] ch);
    case (ch)
      itp_pkg::CH_PLUS:  return itp_pkg::CODE_PLUS;
      itp_pkg::CH_MINUS: return itp_pkg::CODE_MINUS;
      itp_pkg::CH_STAR:  return itp_pkg::CODE_STAR;
      itp_pkg::CH_SLASH: return itp_pkg::CODE_SLASH;
      itp_pkg::CH_CARET: return itp_pkg::CODE_CARET;
      default:           return itp_pkg::CODE_OPEN;
    endcase
  endfunction

  function automatic bit is_ignored(input logic [7:0] ch);
    return !is_operand(ch) && ch != itp_pkg::CH_OPEN && ch != itp_pkg::CH_CLOSE &&
           operator_code(ch) == itp_pkg::CODE_OPEN;
  endfunction

  function automatic int code_rank(input logic [2:0] code);
    case (code)
      itp_pkg::CODE_PLUS, itp_pkg::CODE_MINUS: return 1;
      itp_pkg::CODE_STAR, itp_pkg::CODE_SLASH: return 2;
      itp_pkg::CODE_CARET:                     return 3;
      default:                                 return 0;
    endcase
  endfunction

  function automatic logic [7:0] code_glyph(input logic [2:0] code);
    case (code)
      itp_pkg::CODE_PLUS:  return itp_pkg::CH_PLUS;
      itp_pkg::CODE_MINUS: return itp_pkg::CH_MINUS;
      itp_pkg::CODE_STAR:  return itp_pkg::CH_STAR;
      itp_pkg::CODE_SLASH: return itp_pkg::CH_SLASH;
      itp_pkg::CODE_CARET: return itp_pkg::CH_CARET;
      default:             return itp_pkg::CH_OPEN;
    endcase
  endfunction

  function automatic postfix_t make_result(input logic [7:0] ch, input logic done,
                                           input logic [1:0] st);
    postfix_t r;
    r.out_symbol      = ch;
    r.run_last        = 1'b0;
    r.expression_done = done;
    r.status          = st;
    return r;
  endfunction

  // Pushes a stack code; a full stack drops it and reports overflow.
  task automatic push_code(input logic [2:0] code);
    if (op_depth < STACK_DEPTH) begin
      op_stack[op_depth] = code;
      op_depth++;
    end else begin
      item_run.push_back(make_result(itp_pkg::CH_NUL, 1'b0, itp_pkg::ST_OVERFLOW));
    end
  endtask

  // Works out the postfix results of one accepted character.
  task automatic predict_postfix(input logic [7:0] ch, input logic eoe);
    logic [2:0] code;
    logic [2:0] top;
    logic [1:0] term_status;
    bit         matched;
    item_run.delete();
    code = operator_code(ch);
    if (is_operand(ch)) begin
      item_run.push_back(make_result(ch, 1'b0, itp_pkg::ST_OK));
    end else if (ch == itp_pkg::CH_OPEN) begin
      push_code(itp_pkg::CODE_OPEN);
    end else if (ch == itp_pkg::CH_CLOSE) begin
      matched = 1'b0;
      while (op_depth > 0 && !matched) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top == itp_pkg::CODE_OPEN) begin
          matched = 1'b1;
        end else begin
          item_run.push_back(make_result(code_glyph(top), 1'b0, itp_pkg::ST_OK));
        end
      end
      if (!matched) begin
        item_run.push_back(make_result(itp_pkg::CH_NUL, 1'b0,
                                       itp_pkg::ST_UNMATCHED_CLOSE));
      end
    end else if (code != itp_pkg::CODE_OPEN) begin
      while (op_depth > 0 && op_stack[op_depth - 1] != itp_pkg::CODE_OPEN &&
             code_rank(op_stack[op_depth - 1]) >= code_rank(code)) begin
        item_run.push_back(make_result(code_glyph(op_stack[op_depth - 1]), 1'b0,
                                       itp_pkg::ST_OK));
        op_depth--;
      end
      push_code(code);
    end

    // The end mark flushes the stack and closes the expression.
    if (eoe) begin
      term_status = itp_pkg::ST_OK;
      while (op_depth > 0) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top == itp_pkg::CODE_OPEN) begin
          term_status = itp_pkg::ST_UNMATCHED_OPEN;
        end else begin
          item_run.push_back(make_result(code_glyph(top), 1'b0, itp_pkg::ST_OK));
        end
      end
      item_run.push_back(make_result(itp_pkg::CH_NUL, 1'b1, term_status));
    end

    if (item_run.size() > 0) begin
      item_run[item_run.size() - 1].run_last = 1'b1;
    end
    foreach (item_run[i]) begin
      postfix_expect.push_back(item_run[i]);
    end
  endtask

  // Stimulus building blocks.
  task automatic add_char(input logic [7:0] ch, input logic eoe);
    infix_char_t c;
    c.symbol = ch;
    c.eoe    = eoe;
    feed.push_back(c);
    if (!is_ignored(ch) || eoe) begin
      planned_chars++;
    end
  endtask

  function automatic logic [7:0] pick_noise();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (!is_ignored(ch)) begin
      ch = 8'($urandom_range(0, 255));
    end
    return ch;
  endfunction

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_STAR;
      3:       return itp_pkg::CH_SLASH;
      default: return itp_pkg::CH_CARET;
    endcase
  endfunction

  // Well-formed tokens, with ignored characters sprinkled in when noisy.
  task automatic add_token(input logic [7:0] ch);
    if (noisy && $urandom_range(0, 9) == 0) begin
      add_char(pick_noise(), 1'b0);
    end
    add_char(ch, 1'b0);
  endtask

  task automatic gen_term(input int depth);
    if (depth > 0 && $urandom_range(0, 3) == 0) begin
      add_token(itp_pkg::CH_OPEN);
      gen_sum(depth - 1);
      add_token(itp_pkg::CH_CLOSE);
    end else begin
      add_token(pick_operand());
    end
  endtask

  task automatic gen_sum(input int depth);
    int terms;
    terms = $urandom_range(1, 4);
    gen_term(depth);
    repeat (terms - 1) begin
      add_token(pick_operator());
      gen_term(depth);
    end
  endtask

  task automatic add_text(input string s, input bit close_it);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], close_it && (i == s.len() - 1));
    end
  endtask

  // Directed opening: extremes, all operators and the unmatched-paren statuses.
  task automatic build_directed();
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);
    add_text("(a+b)*c^d-e/9", 1'b1);
    add_text("A+z)", 1'b0);
    add_text("((x-Z", 1'b1);
    add_char(" ", 1'b1);
  endtask

  // Random body: mostly well-formed expressions, mixed with broken, deep and loose ones.
  task automatic build_random();
    int kind;
    int n;
    while (planned_chars < CHAR_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        noisy = ($urandom_range(0, 2) == 0);
        gen_sum($urandom_range(0, 4));
        feed[feed.size() - 1].eoe = 1'b1;
      end else if (kind < 80) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0:       add_char(pick_operand(), 1'b0);
            1:       add_char(pick_operator(), 1'b0);
            2:       add_char(itp_pkg::CH_OPEN, 1'b0);
            default: add_char(itp_pkg::CH_CLOSE, 1'b0);
          endcase
        end
        if ($urandom_range(0, 3) != 0) begin
          feed[feed.size() - 1].eoe = 1'b1;
        end
      end else if (kind < 88) begin
        // Deep nesting that can run the stack into overflow.
        n = $urandom_range(26, 40);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0, 1:    add_char(itp_pkg::CH_OPEN, 1'b0);
            2:       add_char(pick_operator(), 1'b0);
            default: add_char(pick_operand(), 1'b0);
          endcase
        end
        n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 34);
        repeat (n) add_char(itp_pkg::CH_CLOSE, 1'b0);
        add_char(pick_operand(), 1'b1);
      end else if (kind < 94) begin
        add_char(pick_noise(), 1'($urandom_range(0, 1)));
      end else begin
        add_char(pick_operand(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Keep offering the same character until it is taken.
    end else if (gap_left > 0) begin
      gap_left    <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else if (feed.size() > 0) begin
      in_ch.valid             <= 1'b1;
      in_ch.symbol            <= feed[0].symbol;
      in_ch.end_of_expression <= feed[0].eoe;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // One long receiver hold-off so the converter backs up onto its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && chars_in >= 120) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: cycles through free flow, random and heavy stall patterns.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      sink_tick = sink_tick + 1;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        case ((sink_tick / 64) % 4)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (sink_tick % 7 != 3);
        endcase
      end
    end
  end

  // Result check first, then prediction for a newly taken character.
  always @(posedge clk) begin
    postfix_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        status_seen[out_ch.status]++;
        if (out_ch.expression_done) begin
          exprs_closed++;
        end
        if (postfix_expect.size() == 0) begin
          $error("unexpected result: out_symbol %0h status %0d", out_ch.out_symbol,
                 out_ch.status);
          error_count++;
        end else begin
          want = postfix_expect.pop_front();
          if (out_ch.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %0h, got %0h", want.out_symbol, out_ch.out_symbol);
            error_count++;
          end
          if (out_ch.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_ch.run_last);
            error_count++;
          end
          if (out_ch.expression_done !== want.expression_done) begin
            $error("expression_done: expected %0d, got %0d", want.expression_done,
                   out_ch.expression_done);
            error_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            error_count++;
          end
        end
      end
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        void'(feed.pop_front());
        chars_in++;
        predict_postfix(in_ch.symbol, in_ch.end_of_expression);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Build the stimulus, release reset, then wait for the last result.
  initial begin
    rst                     = 1'b1;
    in_ch.valid             = 1'b0;
    in_ch.symbol            = 8'h00;
    in_ch.end_of_expression = 1'b0;
    out_ch.ready            = 1'b0;
    build_directed();
    build_random();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    while (feed.size() != 0 || in_ch.valid) @(posedge clk);
    while (postfix_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters; %0d postfix results checked over %0d expressions.",
             chars_in, results_seen, exprs_closed);
    $display("Status results: %0d overflow, %0d unmatched close, %0d unmatched open.",
             status_seen[itp_pkg::ST_OVERFLOW], status_seen[itp_pkg::ST_UNMATCHED_CLOSE],
             status_seen[itp_pkg::ST_UNMATCHED_OPEN]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[infix_to_postfix_converter.f]
+incdir+src
src/itp_pkg.sv
src/itp_in_if.sv
src/itp_out_if.sv
src/itp_dp.sv
src/itp_ctrl.sv
src/infix_to_postfix_converter.sv
src/itp_checker.sv
tb/infix_to_postfix_converter_tb.sv
